// ----- design/gwm_pkg.sv -----
// ----------------------------------------------------------------------------
// gwm_pkg: shared types and constants for the glob wildcard matcher
// Holds the channel payloads, the per-position pattern view handed to each
// cell, the per-byte step control and the register index codes.
// ----------------------------------------------------------------------------
`default_nettype none

package gwm_pkg;

  // Pattern storage held by the configuration registers
  localparam int CFG_WORDS      = 4;
  localparam int WORD_W         = 64;
  localparam int BYTES_PER_WORD = WORD_W / 8;
  localparam int PAT_BYTES      = CFG_WORDS * BYTES_PER_WORD;
  localparam int LEN_W          = 6;
  localparam int REG_IDX_W      = 3;

  // Register index codes
  localparam logic [REG_IDX_W-1:0] REG_WORD_0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WORD_1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WORD_2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WORD_3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LENGTH = 3'd4;

  // Pattern metacharacters
  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] ANY_CHAR  = 8'h3F;

  // Input item: one filename byte
  typedef struct packed {
    logic [7:0] name_byte;
    logic       name_end;
  } name_item_t;

  // Result item
  typedef struct packed {
    logic matched;
  } result_item_t;

  // Configuration write
  typedef struct packed {
    logic [REG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    value;
  } cfg_write_t;

  // Per-position view of the pattern, as seen by one cell
  typedef struct packed {
    logic       en;    // position lies below the effective length
    logic       star;  // pattern byte is a star
    logic       any;   // pattern byte is a single-character wildcard
    logic [7:0] pat;   // literal pattern byte
  } pos_cfg_t;

  // Step control broadcast to all cells
  typedef struct packed {
    logic       take;  // a name byte transfers this cycle
    logic       last;  // that byte ends the name
    logic [7:0] chr;   // the name byte
  } step_t;

endpackage

`default_nettype wire

// ----- design/gwm_chan_if.sv -----
// ----------------------------------------------------------------------------
// gwm_chan_if: valid/ready channel
// Carries one payload of a parameter type; the source drives valid and data,
// the sink drives ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface gwm_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ----- design/gwm_cell.sv -----
// ----------------------------------------------------------------------------
// gwm_cell: one pattern position of the matcher
// Holds the active bit of its position, extends star closure to its right
// neighbor and hands an advance to it when the name byte is consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_cell import gwm_pkg::*; #(
  parameter logic START = 1'b0
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire step_t    step,
  input  wire pos_cfg_t pcfg,
  input  wire logic     cin,
  input  wire logic     adv_in,
  output logic          cout,
  output logic          adv_out,
  output logic          nxt
);

  logic act;
  logic cur;
  logic hit;

  // Close over stars from the left, then decide stay or advance
  always_comb begin
    cur     = act | cin;
    cout    = cur & pcfg.en & pcfg.star;
    hit     = pcfg.any | (pcfg.pat == step.chr);
    adv_out = cur & pcfg.en & ~pcfg.star & hit;
    nxt     = cout | adv_in;
  end

  // Advance the active bit on each transfer; restart after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      act <= START;
    end else if (step.take) begin
      act <= step.last ? START : nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/gwm_final.sv -----
// ----------------------------------------------------------------------------
// gwm_final: end-of-name evaluation and result register
// Captures the position set left by the last name byte, closes it over
// stars and loads the match bit into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_final import gwm_pkg::*; #(
  parameter int PATTERN_MAX = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire logic [PATTERN_MAX:0]   set_in,
  input  wire logic [PATTERN_MAX-1:0] star_en,
  input  wire logic [LEN_W-1:0]       eff_len,
  output logic                        free,
  gwm_chan_if.source                  result
);

  localparam int IDX_W = $clog2(PATTERN_MAX + 1);

  logic                 fin_valid;
  logic [PATTERN_MAX:0] fin_set;
  logic [PATTERN_MAX:0] closed;
  logic                 out_valid;
  logic                 out_matched;
  logic                 out_load;

  // Move the held set forward when the output register frees up
  assign out_load = fin_valid & (~out_valid | result.ready);
  assign free     = ~fin_valid | out_load;

  // Ripple star closure over the held set
  assign closed[0] = fin_set[0];
  for (genvar p = 0; p < PATTERN_MAX; p++) begin : g_close
    assign closed[p+1] = fin_set[p+1] | (closed[p] & star_en[p]);
  end

  // Hold the final set until the result register takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (load) begin
      fin_valid <= 1'b1;
    end else if (out_load) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fin_set <= set_in;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_matched <= closed[eff_len[IDX_W-1:0]];
    end
  end

  assign result.valid        = out_valid;
  assign result.data.matched = out_matched;

`ifndef SYNTH
  a_load_room: assert property (@(posedge clk) disable iff (rst)
    (load && fin_valid) |-> out_load)
    else $error("final set overwritten before it moved on");
  a_load_held: assert property (@(posedge clk) disable iff (rst)
    load |=> fin_valid)
    else $error("final set lost after load");
  a_out_shown: assert property (@(posedge clk) disable iff (rst)
    out_load |=> result.valid)
    else $error("result not presented after output load");
`endif

endmodule

`default_nettype wire

// ----- design/glob_wildcard_matcher_top.sv -----
// ----------------------------------------------------------------------------
// glob_wildcard_matcher_top: streaming glob matcher
// Matches a filename, one byte per transfer, against a configured pattern
// of up to PATTERN_MAX bytes with star and single-character wildcards.
// ----------------------------------------------------------------------------
// Usage:
//   cfg     - register writes (index 0..3: pattern words, 4: length); always
//             ready. Write only while no name is in flight.
//   name_in - one filename byte per transfer; name_end marks the last byte.
//   result  - one matched bit per name, after its last byte.
// Throughput: one name byte per cycle while name_in.ready is high. A row
//   of position cells updates the active position set on each transfer;
//   star closure ripples along the row. Result path: the final set
//   register, where the set is closed over stars, then the output register.
// Stall: the final set and the output register each hold one result; with
//   both full and result not ready, name_in.ready drops until result moves.
// Reset: pattern and length clear to zero, only position zero is active,
//   no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module glob_wildcard_matcher_top import gwm_pkg::*; #(
  parameter int PATTERN_MAX = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  gwm_chan_if.sink   cfg,
  gwm_chan_if.sink   name_in,
  gwm_chan_if.source result
);

  logic [WORD_W-1:0]    cfg_word [CFG_WORDS];
  logic [LEN_W-1:0]     len_reg;
  logic [LEN_W-1:0]     eff_len;
  logic                 free;
  step_t                step;
  pos_cfg_t             pcfg    [PATTERN_MAX+1];
  logic [PATTERN_MAX:0] chain;
  logic [PATTERN_MAX:0] adv;
  logic [PATTERN_MAX:0] cout;
  logic [PATTERN_MAX:0] nxt;
  logic [PATTERN_MAX-1:0] star_en;

  // Configuration writes; unknown indexes drop
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < CFG_WORDS; w++) begin
        cfg_word[w] <= '0;
      end
      len_reg <= '0;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_WORD_0: cfg_word[0] <= cfg.data.value;
        REG_WORD_1: cfg_word[1] <= cfg.data.value;
        REG_WORD_2: cfg_word[2] <= cfg.data.value;
        REG_WORD_3: cfg_word[3] <= cfg.data.value;
        REG_LENGTH: len_reg     <= cfg.data.value[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length to the row size
  assign eff_len = (len_reg > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_reg;

  // Step control for the row
  assign name_in.ready = free;
  assign step.take     = name_in.valid & free;
  assign step.last     = name_in.data.name_end;
  assign step.chr      = name_in.data.name_byte;

  // Per-position pattern view; bytes past the registers read as zero
  for (genvar p = 0; p <= PATTERN_MAX; p++) begin : g_pos
    if (p < PAT_BYTES) begin : g_reg
      localparam int WI = p / BYTES_PER_WORD;
      localparam int BI = (p % BYTES_PER_WORD) * 8;
      assign pcfg[p].pat = cfg_word[WI][BI +: 8];
    end else begin : g_zero
      assign pcfg[p].pat = '0;
    end
    assign pcfg[p].en   = LEN_W'(p) < eff_len;
    assign pcfg[p].star = pcfg[p].pat == STAR_CHAR;
    assign pcfg[p].any  = pcfg[p].pat == ANY_CHAR;
  end

  // Row of position cells, closure and advance handed rightward
  for (genvar p = 0; p <= PATTERN_MAX; p++) begin : g_cell
    if (p == 0) begin : g_first
      assign chain[p] = 1'b0;
      assign adv[p]   = 1'b0;
    end else begin : g_link
      assign chain[p] = cout[p-1];
    end

    logic adv_out;

    gwm_cell #(
      .START (p == 0)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .step    (step),
      .pcfg    (pcfg[p]),
      .cin     (chain[p]),
      .adv_in  (adv[p]),
      .cout    (cout[p]),
      .adv_out (adv_out),
      .nxt     (nxt[p])
    );

    if (p < PATTERN_MAX) begin : g_fwd
      assign adv[p+1]   = adv_out;
      assign star_en[p] = pcfg[p].en & pcfg[p].star;
    end
  end

  // End-of-name evaluation
  gwm_final #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_final (
    .clk     (clk),
    .rst     (rst),
    .load    (step.take & step.last),
    .set_in  (nxt),
    .star_en (star_en),
    .eff_len (eff_len),
    .free    (free),
    .result  (result)
  );

endmodule

`default_nettype wire
